[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define BLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define BLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/blr_pkg.sv]
// Types and constants of the line rasterizer.
`timescale 1ns / 1ps
package blr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIM_BITS   = 12;
  localparam int COLOR_BITS = 16;
  localparam int ADDR_BITS  = 22;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int PROD_BITS  = COORD_BITS - 1 + DIM_BITS;
  localparam int SUM_BITS   = (PROD_BITS + 1 > ADDR_BITS) ? PROD_BITS + 1 : ADDR_BITS;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 12'd480;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 12'd272;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIM_BITS-1:0] dim_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    logic   op;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t color;
  } blr_in_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    color_t                pixel_color;
    logic                  on_screen;
    logic [ADDR_BITS-1:0]  pixel_addr;
    logic                  last_pixel;
  } blr_out_t;

  // Classified request with the line setup already worked out.
  typedef struct packed {
    logic                         op;
    coord_t                       x_start;
    coord_t                       y_start;
    coord_t                       x_end;
    coord_t                       y_end;
    logic [COORD_BITS-1:0]        delta_x;
    logic signed [COORD_BITS:0]   delta_y_neg;
    logic                         step_x_neg;
    logic                         step_y_neg;
    color_t                       color;
  } blr_cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } blr_pix_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic emit_last;
  } blr_step_stat_t;

endpackage

[hw/rtl/blr_front.sv]
// Front end: classifies requests and computes line setup for start requests.
`timescale 1ns / 1ps
module blr_front
  import blr_pkg::*;
(
  input  logic     in_valid,
  input  blr_in_t  in_data,
  output logic     in_ready,
  output logic     cmd_valid,
  output blr_cmd_t cmd,
  input  logic     q_full
);

  logic signed [COORD_BITS:0] dx_raw;
  logic signed [COORD_BITS:0] dy_raw;
  logic signed [COORD_BITS:0] dx_neg;
  logic signed [COORD_BITS:0] dy_neg;

  assign dx_raw = {in_data.x_end[COORD_BITS-1], in_data.x_end}
                - {in_data.x_start[COORD_BITS-1], in_data.x_start};
  assign dy_raw = {in_data.y_end[COORD_BITS-1], in_data.y_end}
                - {in_data.y_start[COORD_BITS-1], in_data.y_start};
  assign dx_neg = -dx_raw;
  assign dy_neg = -dy_raw;

  assign in_ready  = !q_full;
  assign cmd_valid = in_valid;

  always_comb begin
    cmd             = '0;
    cmd.op          = in_data.op;
    cmd.x_start     = in_data.x_start;
    cmd.y_start     = in_data.y_start;
    cmd.x_end       = in_data.x_end;
    cmd.y_end       = in_data.y_end;
    cmd.color       = in_data.color;
    cmd.delta_x     = dx_raw[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_raw[COORD_BITS-1:0];
    cmd.delta_y_neg = dy_raw[COORD_BITS] ? dy_raw : dy_neg;
    // equal endpoints on an axis count as a negative step
    cmd.step_x_neg  = !(in_data.x_start < in_data.x_end);
    cmd.step_y_neg  = !(in_data.y_start < in_data.y_end);
  end

endmodule

[hw/rtl/blr_queue.sv]
// Short request queue between the front end and the stepper.
`timescale 1ns / 1ps
module blr_queue
  import blr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  blr_cmd_t push_data,
  output logic     full,
  output logic     pop_valid,
  output blr_cmd_t pop_data,
  input  logic     pop_ready
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  blr_cmd_t              mem [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  push, pop;

  assign full      = (count_r == CNT_BITS'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/blr_stepper.sv]
// Back end: holds the line state, emits the first pixel on a start request and advances one pixel per step request.
`timescale 1ns / 1ps
module blr_stepper
  import blr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  blr_cmd_t       cmd,
  output logic           cmd_ready,
  output logic           pix_valid,
  output blr_pix_t       pix,
  input  logic           pix_ready,
  output blr_step_stat_t stat
);

  coord_t                      cur_x_r, cur_x_nxt;
  coord_t                      cur_y_r, cur_y_nxt;
  coord_t                      goal_x_r, goal_x_nxt;
  coord_t                      goal_y_r, goal_y_nxt;
  logic [COORD_BITS-1:0]       dx_r, dx_nxt;
  logic signed [COORD_BITS:0]  dyn_r, dyn_nxt;
  logic                        sxn_r, sxn_nxt;
  logic                        syn_r, syn_nxt;
  logic signed [ERR_BITS-1:0]  err_r, err_nxt;
  color_t                      color_r, color_nxt;
  logic                        busy_r, busy_nxt;
  logic                        pix_vld_r, pix_vld_nxt;
  blr_pix_t                    pix_r, pix_nxt;

  logic                        take;
  logic signed [ERR_BITS:0]    e2;
  logic signed [ERR_BITS:0]    dyn_e;
  logic signed [ERR_BITS:0]    dx_e;
  logic signed [ERR_BITS:0]    dyn_cmd_e;
  logic                        move_x, move_y;
  logic signed [ERR_BITS-1:0]  err_step;
  logic signed [ERR_BITS-1:0]  err_start;
  coord_t                      x_inc, y_inc;
  coord_t                      x_step, y_step;
  logic                        last_step, last_start;

  assign cmd_ready = !pix_vld_r || pix_ready;
  assign take      = cmd_valid && cmd_ready;

  assign e2        = {err_r, 1'b0};
  assign dyn_e     = {{(ERR_BITS - COORD_BITS){dyn_r[COORD_BITS]}}, dyn_r};
  assign dx_e      = {{(ERR_BITS + 1 - COORD_BITS){1'b0}}, dx_r};
  assign dyn_cmd_e = {{(ERR_BITS - COORD_BITS){cmd.delta_y_neg[COORD_BITS]}}, cmd.delta_y_neg};

  assign move_x = (e2 >= dyn_e);
  assign move_y = (e2 <= dx_e);

  assign err_step = err_r
                  + (move_x ? dyn_e[ERR_BITS-1:0] : '0)
                  + (move_y ? dx_e[ERR_BITS-1:0] : '0);
  assign err_start = {{(ERR_BITS - COORD_BITS){1'b0}}, cmd.delta_x}
                   + dyn_cmd_e[ERR_BITS-1:0];

  assign x_inc  = move_x ? (sxn_r ? '1 : COORD_BITS'(1)) : '0;
  assign y_inc  = move_y ? (syn_r ? '1 : COORD_BITS'(1)) : '0;
  assign x_step = cur_x_r + x_inc;
  assign y_step = cur_y_r + y_inc;

  assign last_step  = (x_step == goal_x_r) && (y_step == goal_y_r);
  assign last_start = (cmd.x_start == cmd.x_end) && (cmd.y_start == cmd.y_end);

  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    goal_x_nxt  = goal_x_r;
    goal_y_nxt  = goal_y_r;
    dx_nxt      = dx_r;
    dyn_nxt     = dyn_r;
    sxn_nxt     = sxn_r;
    syn_nxt     = syn_r;
    err_nxt     = err_r;
    color_nxt   = color_r;
    busy_nxt    = busy_r;
    pix_nxt     = pix_r;
    pix_vld_nxt = pix_vld_r && !pix_ready;
    if (take) begin
      case (cmd.op)
        OP_START: begin
          cur_x_nxt   = cmd.x_start;
          cur_y_nxt   = cmd.y_start;
          goal_x_nxt  = cmd.x_end;
          goal_y_nxt  = cmd.y_end;
          dx_nxt      = cmd.delta_x;
          dyn_nxt     = cmd.delta_y_neg;
          sxn_nxt     = cmd.step_x_neg;
          syn_nxt     = cmd.step_y_neg;
          err_nxt     = err_start;
          color_nxt   = cmd.color;
          busy_nxt    = !last_start;
          pix_nxt     = '{x: cmd.x_start, y: cmd.y_start, color: cmd.color, last: last_start};
          pix_vld_nxt = 1'b1;
        end
        OP_STEP: begin
          // a step with no line in progress is dropped
          if (busy_r) begin
            cur_x_nxt   = x_step;
            cur_y_nxt   = y_step;
            err_nxt     = err_step;
            busy_nxt    = !last_step;
            pix_nxt     = '{x: x_step, y: y_step, color: color_r, last: last_step};
            pix_vld_nxt = 1'b1;
          end
        end
        default: begin
          pix_vld_nxt = pix_vld_r && !pix_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pix_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      pix_vld_r <= pix_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    goal_x_r <= goal_x_nxt;
    goal_y_r <= goal_y_nxt;
    dx_r     <= dx_nxt;
    dyn_r    <= dyn_nxt;
    sxn_r    <= sxn_nxt;
    syn_r    <= syn_nxt;
    err_r    <= err_nxt;
    color_r  <= color_nxt;
    pix_r    <= pix_nxt;
  end

  assign pix_valid      = pix_vld_r;
  assign pix            = pix_r;
  assign stat.busy      = busy_r;
  assign stat.emit      = take && ((cmd.op == OP_START) || busy_r);
  assign stat.emit_last = (cmd.op == OP_START) ? last_start : last_step;

endmodule

[hw/rtl/blr_pix_out.sv]
// Clip test and frame address: multiply stage, then add into the output register.
`timescale 1ns / 1ps
module blr_pix_out
  import blr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dim_t     frame_width,
  input  dim_t     frame_height,
  input  logic     pix_valid,
  input  blr_pix_t pix,
  output logic     pix_ready,
  output logic     out_valid,
  output blr_out_t out_data,
  input  logic     out_ready
);

  logic                  s1_vld_r, s1_vld_nxt;
  blr_pix_t              s1_pix_r;
  logic                  s1_on_r;
  logic [PROD_BITS-1:0]  s1_prod_r;
  logic                  s1_ready;
  logic                  s1_take;

  logic                  out_vld_r, out_vld_nxt;
  blr_out_t              out_r;
  logic                  out_take;

  logic                  on_c;
  logic [PROD_BITS-1:0]  prod_c;
  logic [SUM_BITS-1:0]   sum_c;

  assign on_c = !pix.x[COORD_BITS-1] && !pix.y[COORD_BITS-1]
             && (CMP_BITS'($unsigned(pix.x)) < CMP_BITS'(frame_width))
             && (CMP_BITS'($unsigned(pix.y)) < CMP_BITS'(frame_height));
  assign prod_c = PROD_BITS'(pix.y[COORD_BITS-2:0]) * PROD_BITS'(frame_width);

  assign sum_c = SUM_BITS'(s1_prod_r) + SUM_BITS'($unsigned(s1_pix_r.x));

  assign out_take  = s1_vld_r && s1_ready;
  assign s1_ready  = !out_vld_r || out_ready;
  assign pix_ready = !s1_vld_r || s1_ready;
  assign s1_take   = pix_valid && pix_ready;

  assign s1_vld_nxt  = s1_take || (s1_vld_r && !s1_ready);
  assign out_vld_nxt = out_take || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_pix_r  <= pix;
      s1_on_r   <= on_c;
      s1_prod_r <= prod_c;
    end
    if (out_take) begin
      out_r.pixel_x     <= s1_pix_r.x;
      out_r.pixel_y     <= s1_pix_r.y;
      out_r.pixel_color <= s1_pix_r.color;
      out_r.on_screen   <= s1_on_r;
      out_r.pixel_addr  <= s1_on_r ? sum_c[ADDR_BITS-1:0] : '0;
      out_r.last_pixel  <= s1_pix_r.last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/bresenham_line_raster_core.sv]
// Top level of the Bresenham line rasterizer with frame clipping.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_ready  blr_in_t  (op, endpoints, color)
//   out_*        out   out_valid/out_ready blr_out_t (pixel, clip flag, address)
//   cfg_*        in    APB write/read     frame_width @0x0, frame_height @0x4
//
// One request per clock sustained while out_ready stays high; the stepper's
// combinational error update is the recurrence that sets this. A request passes
// through the queue, stepper register, multiply stage and output register.
// rst_n is synchronous: it empties the queue and pipeline and ends any line.
// A stalled out_ready fills the pixel stages, then the queue, then drops in_ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bresenham_line_raster_core
  import blr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  blr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output blr_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dim_t           frame_width_r, frame_width_nxt;
  dim_t           frame_height_r, frame_height_nxt;
  logic           cfg_wr;
  logic           cfg_sel;

  logic           front_vld;
  blr_cmd_t       front_cmd;
  logic           q_full;
  logic           q_vld;
  blr_cmd_t       q_cmd;
  logic           q_ready;
  logic           pix_vld;
  blr_pix_t       pix;
  logic           pix_ready;
  blr_step_stat_t step_stat;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_paddr[2];

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_pwdata[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_pwdata[DIM_BITS-1:0];
        default: begin
          frame_width_nxt = frame_width_r;
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  blr_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cmd_valid (front_vld),
    .cmd       (front_cmd),
    .q_full    (q_full)
  );

  blr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_vld),
    .push_data  (front_cmd),
    .full       (q_full),
    .pop_valid  (q_vld),
    .pop_data   (q_cmd),
    .pop_ready  (q_ready)
  );

  blr_stepper u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_vld),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .pix_valid (pix_vld),
    .pix       (pix),
    .pix_ready (pix_ready),
    .stat      (step_stat)
  );

  blr_pix_out u_pix_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pix_valid    (pix_vld),
    .pix          (pix),
    .pix_ready    (pix_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_ready    (out_ready)
  );

  `BLR_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output valid after reset")
  `BLR_ASSERT(a_last_ends_line, step_stat.emit && step_stat.emit_last |=> !step_stat.busy, "line still busy after last pixel")
  `BLR_ASSERT(a_offscreen_addr_zero, out_valid && !out_data.on_screen |-> out_data.pixel_addr == '0, "address set on off-screen pixel")
  `BLR_ASSERT(a_onscreen_nonneg, out_valid && out_data.on_screen |-> !out_data.pixel_x[COORD_BITS-1] && !out_data.pixel_y[COORD_BITS-1], "negative coordinate flagged on screen")

endmodule
